FILE: rtl/ftsgi_pkg.sv
// Shared constants and types for the FSK tone-split gap interpolator.
package ftsgi_pkg;
   localparam int FrameLength   = 64;
   localparam int SampleBits    = 12;
   localparam int FractionBits  = 8;
   localparam int PosBits       = 6;
   localparam int LevelBits     = 12;
   localparam int ThreshBits    = 13;
   localparam int OutBits       = 20;
   localparam int Lanes         = 4;
   localparam int CsrAddrBits   = 1;
   localparam logic [CsrAddrBits-1:0] RegToneThreshold = 1'b0;
   localparam logic [ThreshBits-1:0]  ThresholdReset   = 13'd2048;

   // One lane's job: start strobe and the blend fraction k/d
   typedef struct packed {
      logic        start;
      logic [PosBits:0] d;
      logic [PosBits:0] k;
   } lane_ctl_type;
endpackage

FILE: rtl/ftsgi_if.sv
// Valid/ready channel carrying one payload word.
interface ftsgi_if #(parameter int W = 8);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ftsgi_lane.sv
// One interpolation lane: numerator build, then restoring divide by d, one bit a cycle.
module ftsgi_lane #(
   parameter int SAMPLE_BITS   = ftsgi_pkg::SampleBits,
   parameter int FRACTION_BITS = ftsgi_pkg::FractionBits
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ftsgi_pkg::lane_ctl_type       ctl,
   input  logic [SAMPLE_BITS-1:0]        base,
   input  logic [SAMPLE_BITS-1:0]        cur,
   output logic                          done,
   output logic [SAMPLE_BITS+FRACTION_BITS-1:0] quot
);
   import ftsgi_pkg::*;
   localparam int NumBits = SAMPLE_BITS + PosBits + 2 + FRACTION_BITS;
   localparam int CntBits = $clog2(NumBits + 1);

   logic [NumBits-1:0]  num_ff, num_in;
   logic [PosBits+1:0]  rem_ff, rem_in;
   logic [PosBits:0]    d_ff, d_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic [SAMPLE_BITS+PosBits+1:0] mix;
   logic [PosBits+2:0]  trial;

   // Weighted sum of both endpoints plus half the divisor
   always_comb begin
      mix = (SAMPLE_BITS+PosBits+2)'(base) * (SAMPLE_BITS+PosBits+2)'(ctl.d - ctl.k)
          + (SAMPLE_BITS+PosBits+2)'(cur) * (SAMPLE_BITS+PosBits+2)'(ctl.k);
      trial = {rem_ff, num_ff[NumBits-1]} - {2'b00, d_ff};
      num_in = num_ff; rem_in = rem_ff; d_in = d_ff; cnt_in = cnt_ff;
      if (ctl.start) begin
         num_in = (NumBits'(mix) << FRACTION_BITS) + NumBits'(ctl.d >> 1);
         rem_in = '0;
         d_in   = ctl.d;
         cnt_in = CntBits'(NumBits);
      end else if (cnt_ff != '0) begin
         // Shift one numerator bit in, subtract when it fits
         if (!trial[PosBits+2]) begin
            rem_in = trial[PosBits+1:0];
            num_in = {num_ff[NumBits-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[PosBits:0], num_ff[NumBits-1]};
            num_in = {num_ff[NumBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
   end

   assign done = (cnt_ff == '0);
   assign quot = num_ff[SAMPLE_BITS+FRACTION_BITS-1:0];
endmodule

FILE: rtl/fsk_tone_split_gap_interpolator_unit.sv
// Top level of the FSK tone-split gap interpolator.
// Each accepted word routes one frame slot to a tone by threshold and emits linearly
// interpolated words for skipped positions of that tone, then the real sample word.
// Four lanes (one per receiver component) share each interpolated entry; each lane's
// divider works through every numerator bit of an entry, and the next entry starts
// only once all lanes are done and the output register is free. Outputs are unsigned
// 12.8 fixed point, rounded half up. Position zero resets both tones' history. Slots
// beyond the frame are dropped.
module fsk_tone_split_gap_interpolator_unit #(
   parameter int FRAME_LENGTH  = ftsgi_pkg::FrameLength,
   parameter int SAMPLE_BITS   = ftsgi_pkg::SampleBits,
   parameter int FRACTION_BITS = ftsgi_pkg::FractionBits
) (
   input  logic clock,
   input  logic reset,
   ftsgi_if.sink   req,
   ftsgi_if.source rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ftsgi_pkg::CsrAddrBits+1:0]  csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import ftsgi_pkg::*;
   localparam int VB = SAMPLE_BITS + FRACTION_BITS;

   typedef enum logic [1:0] {IDLE, GAP, WAITDIV, LAST} state_type;

   state_type                 state_ff;
   logic [ThreshBits-1:0]     thresh_ff;
   logic [PosBits-1:0]        ppos_ff [2];
   logic [SAMPLE_BITS-1:0]    psmp_ff [2][Lanes];
   logic                      tone_ff;
   logic [PosBits-1:0]        pos_ff, last_ff, ent_ff;
   logic [SAMPLE_BITS-1:0]    cur_ff [Lanes];
   logic                      ovalid_ff;
   logic [1+PosBits+4*OutBits:0] odata_ff;
   lane_ctl_type              ctl;
   logic [Lanes-1:0]          ldone;
   logic [VB-1:0]             lq [Lanes];
   logic [OutBits-1:0]        ov [Lanes];
   logic [PosBits-1:0]        in_pos, base_last;
   logic [LevelBits-1:0]      in_lvl;
   logic [SAMPLE_BITS-1:0]    in_s [Lanes];
   logic                      in_tone, wr, out_load;

   // Unpack request word: position, level, rx1_i, rx1_q, rx2_i, rx2_q (first field in MSBs)
   assign in_pos = req.data[PosBits+LevelBits+Lanes*SAMPLE_BITS-1 -: PosBits];
   assign in_lvl = req.data[LevelBits+Lanes*SAMPLE_BITS-1 -: LevelBits];
   for (genvar g = 0; g < Lanes; g++) begin : g_in
      assign in_s[g] = req.data[(Lanes-g)*SAMPLE_BITS-1 -: SAMPLE_BITS];
   end
   assign in_tone = ({1'b0, in_lvl} >= thresh_ff);
   assign base_last = (in_pos == '0) ? '0 : ppos_ff[in_tone];

   assign req.ready = (state_ff == IDLE);
   assign rsp.valid = ovalid_ff;
   assign rsp.data  = odata_ff;

   // Configuration port
   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[CsrAddrBits+1:2] == RegToneThreshold) ?
                       32'(thresh_ff) : 32'd0;

   assign ctl.start = (state_ff == GAP) && (!ovalid_ff || rsp.ready);
   assign ctl.d = {1'b0, pos_ff} - {1'b0, last_ff};
   assign ctl.k = {1'b0, ent_ff} - {1'b0, last_ff};

   // Load the output register with a finished gap word or the real word
   assign out_load = ((state_ff == WAITDIV) && (&ldone)) ||
                     ((state_ff == LAST) && (!ovalid_ff || rsp.ready));

   for (genvar g = 0; g < Lanes; g++) begin : g_lane
      ftsgi_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_lane (
         .clock, .reset, .ctl,
         .base (psmp_ff[tone_ff][g]),
         .cur  (cur_ff[g]),
         .done (ldone[g]),
         .quot (lq[g])
      );
      assign ov[g] = (state_ff == WAITDIV) ? OutBits'(lq[g])
                                           : OutBits'({cur_ff[g], FRACTION_BITS'(0)});
   end

   // Sequencer: accept, sweep gap entries through the lanes, then the real word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         ovalid_ff <= 1'b0;
         thresh_ff <= ThresholdReset;
         ppos_ff[0] <= '0; ppos_ff[1] <= '0;
         for (int t = 0; t < 2; t++)
            for (int c = 0; c < Lanes; c++) psmp_ff[t][c] <= '0;
      end else begin
         if (wr && csr_paddr[CsrAddrBits+1:2] == RegToneThreshold)
            thresh_ff <= csr_pwdata[ThreshBits-1:0];
         if (out_load) ovalid_ff <= 1'b1;
         else if (ovalid_ff && rsp.ready) ovalid_ff <= 1'b0;
         case (state_ff)
            IDLE: begin
               if (req.valid && 32'(in_pos) < FRAME_LENGTH) begin
                  if (in_pos == '0) begin
                     ppos_ff[0] <= '0; ppos_ff[1] <= '0;
                     for (int t = 0; t < 2; t++)
                        for (int c = 0; c < Lanes; c++) psmp_ff[t][c] <= '0;
                  end
                  tone_ff <= in_tone;
                  pos_ff  <= in_pos;
                  last_ff <= base_last;
                  ent_ff  <= base_last + 1'b1;
                  for (int c = 0; c < Lanes; c++) cur_ff[c] <= in_s[c];
                  state_ff <= ({1'b0, in_pos} > {1'b0, base_last} + 1'b1) ? GAP : LAST;
               end
            end
            GAP: if (ctl.start) state_ff <= WAITDIV;
            WAITDIV: begin
               if (&ldone) begin
                  odata_ff  <= {tone_ff, ent_ff, ov[0], ov[1], ov[2], ov[3], 1'b0};
                  ent_ff    <= ent_ff + 1'b1;
                  state_ff  <= (ent_ff + 1'b1 == pos_ff) ? LAST : GAP;
               end
            end
            LAST: begin
               if (!ovalid_ff || rsp.ready) begin
                  odata_ff  <= {tone_ff, pos_ff, ov[0], ov[1], ov[2], ov[3], 1'b1};
                  ppos_ff[tone_ff] <= pos_ff;
                  for (int c = 0; c < Lanes; c++) psmp_ff[tone_ff][c] <= cur_ff[c];
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule
